/* sv/adc_round_robin_scanner_defines.svh */
// assertion helpers shared by the scanner top and the search module
`ifndef ADC_ROUND_ROBIN_SCANNER_DEFINES_SVH
`define ADC_ROUND_ROBIN_SCANNER_DEFINES_SVH

// checked at every rising clock edge outside reset
`define ADCRR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// same check, also enforced while reset is held
`define ADCRR_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

/* sv/adcrr_pkg.sv */
package adcrr_pkg;

    // port field widths
    localparam int MODE_W   = 2;
    localparam int SAMPLE_W = 10;
    localparam int CHAN_W   = 3;
    localparam int MUX_W    = 8;
    localparam int COUNT_W  = 16;
    localparam int MASK_W   = 8;
    localparam int TABLE_W  = 64;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 64;
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 40;

    // item kinds
    localparam logic [MODE_W-1:0] MODE_START  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SAMPLE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ   = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE_MASK = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MUX_TABLE   = 1'd1;

    typedef struct packed {
        logic done;
        logic found;
    } search_status_t;

endpackage

/* sv/adc_round_robin_scanner.sv */
// Scan sequencer for a multi-input converter.
// Input stream s_*: one transfer per item. mode 0 starts a scan at the lowest
// enabled channel, mode 1 delivers a finished conversion for the active channel,
// mode 2 reads back the stored value, valid flag and count of query_channel.
// Result stream m_*: exactly one transfer per input item, carrying the
// conversion request (start_conversion, mux_select), the active channel and the
// read-back fields (zero except for mode 2).
// Configuration: cfg_wr_en writes cfg_wdata to cfg_addr
// (0 enable_mask, 1 mux_table); write only while no item is in flight.
// Order: a read, an ignored sample or an unused mode goes from the idle state to
// the emit state, which loads the output register; a start or a sample during a
// scan first runs the serial channel search, one channel per cycle, over at most
// NUM_CHANNELS channels, and then goes to emit.
// Throughput: one item at a time; s_tready is low from acceptance until the
// result is loaded into the output register, which is then free to wait on
// m_tready while the next item is taken.
// If the receiver stalls, the output holds and the block waits to load the next
// result. Reset clears counts, valid flags, the scan state and both configuration
// registers; stored samples are not reset but read as zero until written.
`include "adc_round_robin_scanner_defines.svh"

module adc_round_robin_scanner #(
    parameter int NUM_CHANNELS = 8,
    parameter int SAMPLE_BITS  = 10,
    parameter int COUNT_BITS   = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [adcrr_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  logic [adcrr_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // mode[1:0], sample[11:2], query_channel[14:12], zero[15]
    input  logic [adcrr_pkg::S_TDATA_W-1:0]     s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // start_conversion[0], mux_select[8:1], active_channel[11:9],
    // read_value[21:12], read_valid[22], read_count[38:23], zero[39]
    output logic [adcrr_pkg::M_TDATA_W-1:0]     m_tdata
);

    import adcrr_pkg::*;

    localparam int CH_W = $clog2(NUM_CHANNELS);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SEARCH = 2'd1;
    localparam logic [1:0] ST_EMIT   = 2'd2;

    logic [1:0] state_reg, state_next;

    logic [MASK_W-1:0]  enable_mask_reg;
    logic [TABLE_W-1:0] mux_table_reg;

    logic [CH_W-1:0] cur_reg, cur_next;
    logic            scanning_reg, scanning_next;

    logic                res_start_reg, res_start_next;
    logic [MUX_W-1:0]    res_mux_reg, res_mux_next;
    logic [SAMPLE_W-1:0] res_value_reg, res_value_next;
    logic                res_valid_reg, res_valid_next;
    logic [COUNT_W-1:0]  res_count_reg, res_count_next;

    logic                m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic [MODE_W-1:0]   in_mode;
    logic [SAMPLE_W-1:0] in_sample;
    logic [CHAN_W-1:0]   in_query;
    logic                in_xfer;
    logic                query_ok;

    logic                   store_wr;
    logic [SAMPLE_BITS-1:0] store_rd_value;
    logic                   store_rd_valid;
    logic [COUNT_BITS-1:0]  store_rd_count;

    logic                  search_start;
    logic [CH_W-1:0]       search_from;
    logic [CH_W-1:0]       search_chan;
    search_status_t        search_status;
    logic                  out_free;

    assign in_mode   = s_tdata[1:0];
    assign in_sample = s_tdata[11:2];
    assign in_query  = s_tdata[14:12];

    assign s_tready = (state_reg == ST_IDLE);
    assign in_xfer  = s_tvalid && s_tready;
    assign query_ok = (32'(in_query) < NUM_CHANNELS);
    assign out_free = !m_tvalid_reg || m_tready;

    assign store_wr = in_xfer && (in_mode == MODE_SAMPLE) && scanning_reg;

    adcrr_store #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .SAMPLE_BITS  (SAMPLE_BITS),
        .COUNT_BITS   (COUNT_BITS)
    ) u_store (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .wr_en     (store_wr),
        .wr_chan   (cur_reg),
        .wr_sample (SAMPLE_BITS'(in_sample)),
        .rd_chan   (in_query[CH_W-1:0]),
        .rd_value  (store_rd_value),
        .rd_valid  (store_rd_valid),
        .rd_count  (store_rd_count)
    );

    // a sample resumes the scan at the channel after the active one
    assign search_from  = (in_mode == MODE_START) ? '0 :
                          (32'(cur_reg) == NUM_CHANNELS - 1) ? '0 : cur_reg + CH_W'(1);
    assign search_start = in_xfer &&
                          ((in_mode == MODE_START) || ((in_mode == MODE_SAMPLE) && scanning_reg));

    adcrr_search #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_search (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (search_start),
        .start_chan (search_from),
        .enable     (enable_mask_reg[NUM_CHANNELS-1:0]),
        .chan       (search_chan),
        .status     (search_status)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_mask_reg <= '0;
            mux_table_reg   <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_ENABLE_MASK: enable_mask_reg <= cfg_wdata[MASK_W-1:0];
                CFG_MUX_TABLE:   mux_table_reg   <= cfg_wdata[TABLE_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        scanning_next  = scanning_reg;
        res_start_next = res_start_reg;
        res_mux_next   = res_mux_reg;
        res_value_next = res_value_reg;
        res_valid_next = res_valid_reg;
        res_count_next = res_count_reg;
        m_tvalid_next  = m_tvalid_reg;
        m_tdata_next   = m_tdata_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    res_start_next = 1'b0;
                    res_mux_next   = '0;
                    res_value_next = '0;
                    res_valid_next = 1'b0;
                    res_count_next = '0;
                    if (search_start) begin
                        state_next = ST_SEARCH;
                    end else begin
                        state_next = ST_EMIT;
                    end
                    if ((in_mode == MODE_READ) && query_ok) begin
                        res_value_next = SAMPLE_W'(store_rd_value);
                        res_valid_next = store_rd_valid;
                        res_count_next = COUNT_W'(store_rd_count);
                    end
                end
            end
            ST_SEARCH: begin
                if (search_status.done) begin
                    state_next = ST_EMIT;
                    if (search_status.found) begin
                        cur_next       = search_chan;
                        scanning_next  = 1'b1;
                        res_start_next = 1'b1;
                        res_mux_next   = mux_table_reg[MUX_W*search_chan +: MUX_W];
                    end else begin
                        scanning_next = 1'b0;
                    end
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    state_next    = ST_IDLE;
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {1'b0, res_count_reg, res_valid_reg, res_value_reg,
                                     CHAN_W'(cur_reg), res_mux_reg, res_start_reg};
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        res_start_reg <= res_start_next;
        res_mux_reg   <= res_mux_next;
        res_value_reg <= res_value_next;
        res_valid_reg <= res_valid_next;
        res_count_reg <= res_count_next;
        m_tdata_reg   <= m_tdata_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cur_reg      <= '0;
            scanning_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cur_reg      <= cur_next;
            scanning_reg <= scanning_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `ADCRR_ASSERT(a_result_from_emit, $rose(m_tvalid_reg) |-> $past(state_reg == ST_EMIT), "result loaded outside emit")
    `ADCRR_ASSERT(a_done_in_search, search_status.done |-> state_reg == ST_SEARCH, "search finished outside search state")
    `ADCRR_ASSERT(a_item_leaves_idle, in_xfer |=> state_reg != ST_IDLE, "accepted item was dropped")

endmodule

/* sv/adcrr_store.sv */
module adcrr_store #(
    parameter int NUM_CHANNELS = 8,
    parameter int SAMPLE_BITS  = 10,
    parameter int COUNT_BITS   = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            wr_en,
    input  logic [$clog2(NUM_CHANNELS)-1:0] wr_chan,
    input  logic [SAMPLE_BITS-1:0]          wr_sample,
    input  logic [$clog2(NUM_CHANNELS)-1:0] rd_chan,
    output logic [SAMPLE_BITS-1:0]          rd_value,
    output logic                            rd_valid,
    output logic [COUNT_BITS-1:0]           rd_count
);

    logic [SAMPLE_BITS-1:0] sample_reg [NUM_CHANNELS];
    logic [COUNT_BITS-1:0]  count_reg  [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] valid_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            sample_reg[wr_chan] <= wr_sample;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                count_reg[i] <= '0;
            end
        end else if (wr_en) begin
            valid_reg[wr_chan] <= 1'b1;
            count_reg[wr_chan] <= count_reg[wr_chan] + COUNT_BITS'(1);
        end
    end

    // a channel never sampled reads as zero
    assign rd_valid = valid_reg[rd_chan];
    assign rd_value = valid_reg[rd_chan] ? sample_reg[rd_chan] : '0;
    assign rd_count = count_reg[rd_chan];

endmodule

/* sv/adcrr_search.sv */
`include "adc_round_robin_scanner_defines.svh"

module adcrr_search #(
    parameter int NUM_CHANNELS = 8
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 start,
    input  logic [$clog2(NUM_CHANNELS)-1:0]      start_chan,
    input  logic [NUM_CHANNELS-1:0]              enable,
    output logic [$clog2(NUM_CHANNELS)-1:0]      chan,
    output adcrr_pkg::search_status_t            status
);

    import adcrr_pkg::*;

    localparam int CH_W = $clog2(NUM_CHANNELS);

    logic            busy_reg, busy_next;
    logic [CH_W-1:0] cand_reg, cand_next;
    logic [CH_W-1:0] steps_reg, steps_next;
    logic            hit;
    logic            last_step;

    // one candidate channel is tested per cycle, wrapping at the top
    assign hit       = enable[cand_reg];
    assign last_step = (32'(steps_reg) == NUM_CHANNELS - 1);

    assign status.done  = busy_reg && (hit || last_step);
    assign status.found = busy_reg && hit;
    assign chan         = cand_reg;

    always_comb begin
        busy_next  = busy_reg;
        cand_next  = cand_reg;
        steps_next = steps_reg;
        if (start) begin
            busy_next  = 1'b1;
            cand_next  = start_chan;
            steps_next = '0;
        end else if (busy_reg) begin
            if (status.done) begin
                busy_next = 1'b0;
            end else begin
                cand_next  = (32'(cand_reg) == NUM_CHANNELS - 1) ? '0 : cand_reg + CH_W'(1);
                steps_next = steps_reg + CH_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            cand_reg  <= '0;
            steps_reg <= '0;
        end else begin
            busy_reg  <= busy_next;
            cand_reg  <= cand_next;
            steps_reg <= steps_next;
        end
    end

    `ADCRR_ASSERT(a_done_ends_search, status.done && !start |=> !busy_reg, "search still busy after done")
    `ADCRR_ASSERT(a_steps_bounded, busy_reg |-> 32'(steps_reg) < NUM_CHANNELS, "search ran past all channels")
    `ADCRR_ASSERT_ALWAYS(a_idle_no_done, !busy_reg |-> !status.done, "done reported while idle")

endmodule
